// File: src/mlp_online_sgd_trainer_unit_macros.svh
// assertion helpers shared by the checker
`ifndef MLP_ONLINE_SGD_TRAINER_UNIT_MACROS_SVH
`define MLP_ONLINE_SGD_TRAINER_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define MLPSGD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlpsgd check failed");

// next-cycle implication
`define MLPSGD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlpsgd check failed");

`endif

// File: src/mlpsgd_pkg.sv
`default_nettype none
package mlpsgd_pkg;

  localparam int NUM_INPUTS_DEF  = 2;
  localparam int NUM_HIDDEN_DEF  = 25;
  localparam int NUM_OUTPUTS_DEF = 6;
  localparam int FRAC_BITS_DEF   = 24;
  localparam int MAX_OUTPUTS     = 6;
  localparam logic [24:0] LR_RESET = 25'd16777;

  typedef enum logic [1:0] {
    KIND_INFER = 2'd0,
    KIND_TRAIN = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         param_index;
    logic signed [31:0] param_value;
    logic signed [31:0] feature_current;
    logic signed [31:0] feature_energy;
    logic signed [31:0] target_0;
    logic signed [31:0] target_1;
    logic signed [31:0] target_2;
    logic signed [31:0] target_3;
    logic signed [31:0] target_4;
    logic signed [31:0] target_5;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] prediction_0;
    logic signed [31:0] prediction_1;
    logic signed [31:0] prediction_2;
    logic signed [31:0] prediction_3;
    logic signed [31:0] prediction_4;
    logic signed [31:0] prediction_5;
    logic [30:0]        peak_error;
    logic signed [31:0] param_readback;
  } out_item_t;

  typedef struct packed {
    logic               mul_en;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] add_a;
    logic signed [31:0] add_b;
    logic               add_sub;
  } mac_req_t;

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_READ, S_READ_CAP,
    S_FH_RD, S_FH_MUL, S_FH_ADD, S_FH_BRD, S_FH_BADD,
    S_FO_RD, S_FO_MUL, S_FO_ADD, S_FO_BRD, S_FO_BADD,
    S_UD_DELTA, S_UD_STEP, S_UD_SAVE,
    S_UO_RD, S_UO_MUL, S_UO_W, S_UO_MUL2, S_UO_E, S_UO_BRD, S_UO_BW,
    S_UH_RD, S_UH_MUL, S_UH_STEP, S_UH_WRD, S_UH_MUL2, S_UH_WW, S_UH_BRD, S_UH_BW,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: src/mlp_online_sgd_trainer_unit.sv
// Online trainer for a small ReLU perceptron in signed fixed point.
// Input channel in_valid/in_ready/in_data carries one item: infer, train,
// load parameter or read parameter. Output channel out_valid/out_ready/
// out_data returns exactly one result beat per item.
// cfg_we/cfg_data write the learning rate; write it only while idle.
// All arithmetic runs through one multiply/saturating-add unit under a
// sequencer; each multiply-accumulate runs in three steps (store read,
// multiply, add) because the parameter store has one registered read port.
// One item is processed at a time; in_ready is high only while the
// sequencer is idle.
// The result sits in an output register; the block takes the next item while
// it waits, and a new result is held back until the receiver takes the old one.
// Reset clears the sequencer, the output valid and sets the learning rate to
// about 0.001; the parameter store is not cleared and must be loaded first.
`default_nettype none
module mlp_online_sgd_trainer_unit #(
  parameter int NUM_INPUTS  = mlpsgd_pkg::NUM_INPUTS_DEF,
  parameter int NUM_HIDDEN  = mlpsgd_pkg::NUM_HIDDEN_DEF,
  parameter int NUM_OUTPUTS = mlpsgd_pkg::NUM_OUTPUTS_DEF,
  parameter int FRAC_BITS   = mlpsgd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire mlpsgd_pkg::in_item_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mlpsgd_pkg::out_item_t     out_data,
  input  wire logic                 cfg_we,
  input  wire logic [24:0]          cfg_data
);

  localparam int W2_BASE = NUM_INPUTS * NUM_HIDDEN;
  localparam int HB_BASE = W2_BASE + NUM_HIDDEN * NUM_OUTPUTS;
  localparam int OB_BASE = HB_BASE + NUM_HIDDEN;
  localparam int STORE_SIZE = OB_BASE + NUM_OUTPUTS;
  localparam int AW = $clog2(STORE_SIZE);
  localparam int HW = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

  mlpsgd_pkg::state_t state, state_next;
  mlpsgd_pkg::in_item_t item;
  mlpsgd_pkg::mac_req_t req;

  logic [24:0] learning_rate;
  logic [HW-1:0] k;
  logic [2:0] j;
  logic i;
  logic signed [31:0] acc, delta, step, wnew, readback;
  logic signed [31:0] y [mlpsgd_pkg::MAX_OUTPUTS];
  logic [30:0] peak;

  logic signed [31:0] store_mem [STORE_SIZE];
  logic signed [31:0] hact_mem [NUM_HIDDEN];
  logic signed [31:0] herr_mem [NUM_HIDDEN];
  logic signed [31:0] st_rdata, ha_rdata, he_rdata;
  logic st_re, st_we, ha_re, ha_we, he_re, he_we;
  logic [AW-1:0] st_ra, st_wa;
  logic signed [31:0] st_wd, ha_wd, he_wd;

  logic signed [31:0] prod, sum, xsel, tsel, hdelta;
  logic [AW-1:0] a_w1, a_w2, a_hb, a_ob;
  logic idx_ok, k_last, j_last, i_last;
  logic [31:0] mag;

  assign in_ready = (state == mlpsgd_pkg::S_IDLE);

  always_comb begin
    a_w1 = AW'(i) * AW'(NUM_HIDDEN) + AW'(k);
    a_w2 = AW'(W2_BASE) + AW'(j) * AW'(NUM_HIDDEN) + AW'(k);
    a_hb = AW'(HB_BASE) + AW'(k);
    a_ob = AW'(OB_BASE) + AW'(j);
    idx_ok = (32'(item.param_index) < 32'(STORE_SIZE));
    k_last = (k == HW'(NUM_HIDDEN - 1));
    j_last = (j == 3'(NUM_OUTPUTS - 1));
    i_last = (i == 1'(NUM_INPUTS - 1));
    xsel = (NUM_INPUTS > 1 && i) ? item.feature_energy : item.feature_current;
    case (j)
      3'd0: tsel = item.target_0;
      3'd1: tsel = item.target_1;
      3'd2: tsel = item.target_2;
      3'd3: tsel = item.target_3;
      3'd4: tsel = item.target_4;
      3'd5: tsel = item.target_5;
      default: tsel = item.target_0;
    endcase
    hdelta = (ha_rdata > 32'sd0) ? he_rdata : 32'sd0;
    // |delta| with the most negative value clamped
    if (sum == 32'sh80000000) begin
      mag = 32'h7fffffff;
    end else if (sum[31]) begin
      mag = 32'(-sum);
    end else begin
      mag = 32'(sum);
    end
  end

  mlpsgd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk  (clk),
    .req  (req),
    .prod (prod),
    .sum  (sum)
  );

  // sequencer: next state, memory strobes and shared unit operands
  always_comb begin
    state_next = state;
    req = '0;
    st_re = 1'b0;
    st_ra = a_w1;
    st_we = 1'b0;
    st_wa = a_w2;
    st_wd = sum;
    ha_re = 1'b0;
    ha_we = 1'b0;
    ha_wd = (sum > 32'sd0) ? sum : 32'sd0;
    he_re = 1'b0;
    he_we = 1'b0;
    he_wd = sum;
    case (state)
      mlpsgd_pkg::S_IDLE: begin
        if (in_valid) begin
          case (mlpsgd_pkg::kind_t'(in_data.kind))
            mlpsgd_pkg::KIND_LOAD: state_next = mlpsgd_pkg::S_LOAD;
            mlpsgd_pkg::KIND_READ: state_next = mlpsgd_pkg::S_READ;
            default: state_next = mlpsgd_pkg::S_FH_RD;
          endcase
        end
      end
      mlpsgd_pkg::S_LOAD: begin
        st_we = idx_ok;
        st_wa = AW'(item.param_index);
        st_wd = item.param_value;
        state_next = mlpsgd_pkg::S_DONE;
      end
      mlpsgd_pkg::S_READ: begin
        st_re = idx_ok;
        st_ra = AW'(item.param_index);
        state_next = mlpsgd_pkg::S_READ_CAP;
      end
      mlpsgd_pkg::S_READ_CAP: state_next = mlpsgd_pkg::S_DONE;
      mlpsgd_pkg::S_FH_RD: begin
        st_re = 1'b1;
        st_ra = a_w1;
        state_next = mlpsgd_pkg::S_FH_MUL;
      end
      mlpsgd_pkg::S_FH_MUL: begin
        req.mul_en = 1'b1;
        req.mul_a = st_rdata;
        req.mul_b = xsel;
        state_next = mlpsgd_pkg::S_FH_ADD;
      end
      mlpsgd_pkg::S_FH_ADD: begin
        req.add_a = acc;
        req.add_b = prod;
        state_next = i_last ? mlpsgd_pkg::S_FH_BRD : mlpsgd_pkg::S_FH_RD;
      end
      mlpsgd_pkg::S_FH_BRD: begin
        st_re = 1'b1;
        st_ra = a_hb;
        state_next = mlpsgd_pkg::S_FH_BADD;
      end
      mlpsgd_pkg::S_FH_BADD: begin
        req.add_a = acc;
        req.add_b = st_rdata;
        ha_we = 1'b1;
        state_next = k_last ? mlpsgd_pkg::S_FO_RD : mlpsgd_pkg::S_FH_RD;
      end
      mlpsgd_pkg::S_FO_RD: begin
        st_re = 1'b1;
        st_ra = a_w2;
        ha_re = 1'b1;
        state_next = mlpsgd_pkg::S_FO_MUL;
      end
      mlpsgd_pkg::S_FO_MUL: begin
        req.mul_en = 1'b1;
        req.mul_a = st_rdata;
        req.mul_b = ha_rdata;
        state_next = mlpsgd_pkg::S_FO_ADD;
      end
      mlpsgd_pkg::S_FO_ADD: begin
        req.add_a = acc;
        req.add_b = prod;
        state_next = k_last ? mlpsgd_pkg::S_FO_BRD : mlpsgd_pkg::S_FO_RD;
      end
      mlpsgd_pkg::S_FO_BRD: begin
        st_re = 1'b1;
        st_ra = a_ob;
        state_next = mlpsgd_pkg::S_FO_BADD;
      end
      mlpsgd_pkg::S_FO_BADD: begin
        req.add_a = acc;
        req.add_b = st_rdata;
        if (!j_last) begin
          state_next = mlpsgd_pkg::S_FO_RD;
        end else if (item.kind == mlpsgd_pkg::KIND_TRAIN) begin
          state_next = mlpsgd_pkg::S_UD_DELTA;
        end else begin
          state_next = mlpsgd_pkg::S_DONE;
        end
      end
      mlpsgd_pkg::S_UD_DELTA: begin
        req.add_a = tsel;
        req.add_b = y[j];
        req.add_sub = 1'b1;
        state_next = mlpsgd_pkg::S_UD_STEP;
      end
      mlpsgd_pkg::S_UD_STEP: begin
        req.mul_en = 1'b1;
        req.mul_a = $signed({7'd0, learning_rate});
        req.mul_b = delta;
        state_next = mlpsgd_pkg::S_UD_SAVE;
      end
      mlpsgd_pkg::S_UD_SAVE: state_next = mlpsgd_pkg::S_UO_RD;
      mlpsgd_pkg::S_UO_RD: begin
        st_re = 1'b1;
        st_ra = a_w2;
        ha_re = 1'b1;
        he_re = 1'b1;
        state_next = mlpsgd_pkg::S_UO_MUL;
      end
      mlpsgd_pkg::S_UO_MUL: begin
        req.mul_en = 1'b1;
        req.mul_a = step;
        req.mul_b = ha_rdata;
        state_next = mlpsgd_pkg::S_UO_W;
      end
      mlpsgd_pkg::S_UO_W: begin
        req.add_a = st_rdata;
        req.add_b = prod;
        st_we = 1'b1;
        st_wa = a_w2;
        state_next = mlpsgd_pkg::S_UO_MUL2;
      end
      mlpsgd_pkg::S_UO_MUL2: begin
        req.mul_en = 1'b1;
        req.mul_a = delta;
        req.mul_b = wnew;
        state_next = mlpsgd_pkg::S_UO_E;
      end
      mlpsgd_pkg::S_UO_E: begin
        // first output row starts the error sums from zero
        req.add_a = (j == 3'd0) ? 32'sd0 : he_rdata;
        req.add_b = prod;
        he_we = 1'b1;
        state_next = k_last ? mlpsgd_pkg::S_UO_BRD : mlpsgd_pkg::S_UO_RD;
      end
      mlpsgd_pkg::S_UO_BRD: begin
        st_re = 1'b1;
        st_ra = a_ob;
        state_next = mlpsgd_pkg::S_UO_BW;
      end
      mlpsgd_pkg::S_UO_BW: begin
        req.add_a = st_rdata;
        req.add_b = step;
        st_we = 1'b1;
        st_wa = a_ob;
        state_next = j_last ? mlpsgd_pkg::S_UH_RD : mlpsgd_pkg::S_UD_DELTA;
      end
      mlpsgd_pkg::S_UH_RD: begin
        ha_re = 1'b1;
        he_re = 1'b1;
        state_next = mlpsgd_pkg::S_UH_MUL;
      end
      mlpsgd_pkg::S_UH_MUL: begin
        req.mul_en = 1'b1;
        req.mul_a = $signed({7'd0, learning_rate});
        req.mul_b = hdelta;
        state_next = mlpsgd_pkg::S_UH_STEP;
      end
      mlpsgd_pkg::S_UH_STEP: state_next = mlpsgd_pkg::S_UH_WRD;
      mlpsgd_pkg::S_UH_WRD: begin
        st_re = 1'b1;
        st_ra = a_w1;
        state_next = mlpsgd_pkg::S_UH_MUL2;
      end
      mlpsgd_pkg::S_UH_MUL2: begin
        req.mul_en = 1'b1;
        req.mul_a = step;
        req.mul_b = xsel;
        state_next = mlpsgd_pkg::S_UH_WW;
      end
      mlpsgd_pkg::S_UH_WW: begin
        req.add_a = st_rdata;
        req.add_b = prod;
        st_we = 1'b1;
        st_wa = a_w1;
        state_next = i_last ? mlpsgd_pkg::S_UH_BRD : mlpsgd_pkg::S_UH_WRD;
      end
      mlpsgd_pkg::S_UH_BRD: begin
        st_re = 1'b1;
        st_ra = a_hb;
        state_next = mlpsgd_pkg::S_UH_BW;
      end
      mlpsgd_pkg::S_UH_BW: begin
        req.add_a = st_rdata;
        req.add_b = step;
        st_we = 1'b1;
        st_wa = a_hb;
        state_next = k_last ? mlpsgd_pkg::S_DONE : mlpsgd_pkg::S_UH_RD;
      end
      mlpsgd_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = mlpsgd_pkg::S_IDLE;
        end
      end
      default: state_next = mlpsgd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlpsgd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= mlpsgd_pkg::LR_RESET;
    end else if (cfg_we) begin
      learning_rate <= cfg_data;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    if (st_re) begin
      st_rdata <= store_mem[st_ra];
    end
    if (ha_we) begin
      hact_mem[k] <= ha_wd;
    end
    if (ha_re) begin
      ha_rdata <= hact_mem[k];
    end
    if (he_we) begin
      herr_mem[k] <= he_wd;
    end
    if (he_re) begin
      he_rdata <= herr_mem[k];
    end
  end

  // datapath registers and loop counters
  always_ff @(posedge clk) begin
    case (state)
      mlpsgd_pkg::S_IDLE: begin
        if (in_valid) begin
          item <= in_data;
          acc <= '0;
          i <= 1'b0;
          j <= '0;
          k <= '0;
          peak <= '0;
          readback <= '0;
          for (int n = 0; n < mlpsgd_pkg::MAX_OUTPUTS; n++) begin
            y[n] <= '0;
          end
        end
      end
      mlpsgd_pkg::S_READ_CAP: readback <= idx_ok ? st_rdata : 32'sd0;
      mlpsgd_pkg::S_FH_ADD: begin
        acc <= sum;
        i <= i_last ? 1'b0 : 1'b1;
      end
      mlpsgd_pkg::S_FH_BADD: begin
        acc <= '0;
        k <= k_last ? '0 : k + 1'b1;
      end
      mlpsgd_pkg::S_FO_ADD: begin
        acc <= sum;
        if (!k_last) begin
          k <= k + 1'b1;
        end
      end
      mlpsgd_pkg::S_FO_BADD: begin
        y[j] <= sum;
        acc <= '0;
        k <= '0;
        j <= j_last ? 3'd0 : j + 3'd1;
      end
      mlpsgd_pkg::S_UD_DELTA: begin
        delta <= sum;
        if (mag[30:0] > peak) begin
          peak <= mag[30:0];
        end
      end
      mlpsgd_pkg::S_UD_SAVE: begin
        step <= prod;
        k <= '0;
      end
      mlpsgd_pkg::S_UO_W: wnew <= sum;
      mlpsgd_pkg::S_UO_E: begin
        if (!k_last) begin
          k <= k + 1'b1;
        end
      end
      mlpsgd_pkg::S_UO_BW: begin
        k <= '0;
        j <= j + 3'd1;
      end
      mlpsgd_pkg::S_UH_STEP: begin
        step <= prod;
        i <= 1'b0;
      end
      mlpsgd_pkg::S_UH_WW: i <= i_last ? 1'b0 : 1'b1;
      mlpsgd_pkg::S_UH_BW: k <= k + 1'b1;
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mlpsgd_pkg::S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mlpsgd_pkg::S_DONE && (!out_valid || out_ready)) begin
      out_data.prediction_0 <= (NUM_OUTPUTS > 0) ? y[0] : 32'sd0;
      out_data.prediction_1 <= (NUM_OUTPUTS > 1) ? y[1] : 32'sd0;
      out_data.prediction_2 <= (NUM_OUTPUTS > 2) ? y[2] : 32'sd0;
      out_data.prediction_3 <= (NUM_OUTPUTS > 3) ? y[3] : 32'sd0;
      out_data.prediction_4 <= (NUM_OUTPUTS > 4) ? y[4] : 32'sd0;
      out_data.prediction_5 <= (NUM_OUTPUTS > 5) ? y[5] : 32'sd0;
      out_data.peak_error <= peak;
      out_data.param_readback <= readback;
    end
  end

endmodule
`default_nettype wire

// File: src/mlpsgd_mac.sv
`default_nettype none
module mlpsgd_mac #(
  parameter int FRAC_BITS = mlpsgd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire mlpsgd_pkg::mac_req_t req,
  output logic signed [31:0]        prod,
  output logic signed [31:0]        sum
);

  logic signed [63:0] p;
  logic signed [63:0] r;
  logic signed [31:0] p_sat;
  logic signed [32:0] s;

  // fixed-point product, floor shift, then saturate
  always_comb begin
    p = 64'(req.mul_a) * 64'(req.mul_b);
    r = p >>> FRAC_BITS;
    if (r > 64'sd2147483647) begin
      p_sat = 32'sh7fffffff;
    end else if (r < -64'sd2147483648) begin
      p_sat = 32'sh80000000;
    end else begin
      p_sat = r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod <= p_sat;
    end
  end

  always_comb begin
    if (req.add_sub) begin
      s = {req.add_a[31], req.add_a} - {req.add_b[31], req.add_b};
    end else begin
      s = {req.add_a[31], req.add_a} + {req.add_b[31], req.add_b};
    end
    if (s[32] != s[31]) begin
      sum = s[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      sum = s[31:0];
    end
  end

endmodule
`default_nettype wire

// File: src/mlpsgd_checker.sv
`default_nettype none
`include "mlp_online_sgd_trainer_unit_macros.svh"
module mlpsgd_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire mlpsgd_pkg::out_item_t out_data
);

  // a held result beat stays put
  `MLPSGD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `MLPSGD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  // one item at a time: busy right after an accept
  `MLPSGD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // readback only on read items, peak error only on train items
  `MLPSGD_ASSERT_NOW(a_kinds_exclusive,
    out_valid && out_data.param_readback != 32'sd0, out_data.peak_error == 31'd0)

endmodule

bind mlp_online_sgd_trainer_unit mlpsgd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_IN   = 2;
  localparam int N_HID  = 25;
  localparam int N_OUT  = 6;
  localparam int FRAC   = 24;
  localparam int W2_OFS = N_IN * N_HID;
  localparam int HB_OFS = W2_OFS + N_HID * N_OUT;
  localparam int OB_OFS = HB_OFS + N_HID;
  localparam int STORE_N = OB_OFS + N_OUT;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mlpsgd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mlpsgd_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [24:0] cfg_data = '0;

  always #6 clk = ~clk;

  mlp_online_sgd_trainer_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // shadow of the network state
  logic signed [31:0] weights [STORE_N];
  logic signed [31:0] act [N_HID];
  logic signed [31:0] err_sum [N_HID];
  logic [24:0] lr_shadow = mlpsgd_pkg::LR_RESET;

  mlpsgd_pkg::in_item_t item_q [$];
  mlpsgd_pkg::out_item_t result_q [$];
  int n_queued = 0;
  int n_taken = 0;
  int n_errors = 0;
  int n_results = 0;
  int kind_cnt [4] = '{0, 0, 0, 0};
  int idle_pct = 0;
  int stall_pct = 0;
  logic took = 1'b0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
    return sat32(longint'(a) + longint'(b));
  endfunction

  // floor of the scaled product, then saturate
  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> FRAC);
  endfunction

  function automatic mlpsgd_pkg::out_item_t predict_result(mlpsgd_pkg::in_item_t it);
    mlpsgd_pkg::out_item_t r;
    logic signed [31:0] x [N_IN];
    logic signed [31:0] d [N_OUT];
    logic signed [31:0] y [N_OUT];
    logic signed [31:0] z, delta, step, lr_q;
    longint mag;
    logic [30:0] peak;
    r = '0;
    peak = '0;
    lr_q = {7'b0, lr_shadow};
    x[0] = it.feature_current;
    x[1] = it.feature_energy;
    d = '{it.target_0, it.target_1, it.target_2, it.target_3, it.target_4, it.target_5};
    foreach (y[j]) y[j] = '0;
    case (mlpsgd_pkg::kind_t'(it.kind))
      mlpsgd_pkg::KIND_INFER, mlpsgd_pkg::KIND_TRAIN: begin
        for (int k = 0; k < N_HID; k++) begin
          z = '0;
          for (int i = 0; i < N_IN; i++) z = qadd(z, qmul(weights[i * N_HID + k], x[i]));
          z = qadd(z, weights[HB_OFS + k]);
          act[k] = (z > 0) ? z : '0;
        end
        for (int j = 0; j < N_OUT; j++) begin
          z = '0;
          for (int k = 0; k < N_HID; k++)
            z = qadd(z, qmul(weights[W2_OFS + j * N_HID + k], act[k]));
          y[j] = qadd(z, weights[OB_OFS + j]);
        end
        if (mlpsgd_pkg::kind_t'(it.kind) == mlpsgd_pkg::KIND_TRAIN) begin
          foreach (err_sum[k]) err_sum[k] = '0;
          // output layer first; hidden errors see the updated weights
          for (int j = 0; j < N_OUT; j++) begin
            delta = sat32(longint'(d[j]) - longint'(y[j]));
            mag = (delta < 0) ? -longint'(delta) : longint'(delta);
            if (mag > longint'(Q_MAX)) mag = longint'(Q_MAX);
            if (mag > longint'(peak)) peak = mag[30:0];
            step = qmul(lr_q, delta);
            for (int k = 0; k < N_HID; k++) begin
              weights[W2_OFS + j * N_HID + k] =
                qadd(weights[W2_OFS + j * N_HID + k], qmul(step, act[k]));
              err_sum[k] = qadd(err_sum[k], qmul(delta, weights[W2_OFS + j * N_HID + k]));
            end
            weights[OB_OFS + j] = qadd(weights[OB_OFS + j], step);
          end
          for (int k = 0; k < N_HID; k++) begin
            delta = (act[k] > 0) ? err_sum[k] : '0;
            step = qmul(lr_q, delta);
            for (int i = 0; i < N_IN; i++)
              weights[i * N_HID + k] = qadd(weights[i * N_HID + k], qmul(step, x[i]));
            weights[HB_OFS + k] = qadd(weights[HB_OFS + k], step);
          end
        end
      end
      mlpsgd_pkg::KIND_LOAD: begin
        if (it.param_index < STORE_N) weights[it.param_index] = it.param_value;
      end
      default: begin
        if (it.param_index < STORE_N) r.param_readback = weights[it.param_index];
      end
    endcase
    r.prediction_0 = y[0];
    r.prediction_1 = y[1];
    r.prediction_2 = y[2];
    r.prediction_3 = y[3];
    r.prediction_4 = y[4];
    r.prediction_5 = y[5];
    r.peak_error = peak;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // sender: hold until taken, then maybe idle
  always @(negedge clk) begin
    if (!rst && (!in_valid || took)) begin
      if (item_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data <= item_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    mlpsgd_pkg::out_item_t want;
    took <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      result_q = {result_q, predict_result(in_data)};
      kind_cnt[in_data.kind]++;
      n_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with nothing expected, got %h", $realtime, out_data);
      end else begin
        want = result_q.pop_front();
        check_field("prediction_0", want.prediction_0, out_data.prediction_0);
        check_field("prediction_1", want.prediction_1, out_data.prediction_1);
        check_field("prediction_2", want.prediction_2, out_data.prediction_2);
        check_field("prediction_3", want.prediction_3, out_data.prediction_3);
        check_field("prediction_4", want.prediction_4, out_data.prediction_4);
        check_field("prediction_5", want.prediction_5, out_data.prediction_5);
        check_field("peak_error", want.peak_error, out_data.peak_error);
        check_field("param_readback", want.param_readback, out_data.param_readback);
      end
    end
  end

  // mostly values within +-2^b, now and then any 32-bit pattern
  function automatic logic signed [31:0] pick_q(int b);
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(0, 2 ** (b + 1))) - (2 ** b);
  endfunction

  function automatic mlpsgd_pkg::in_item_t make_item(mlpsgd_pkg::kind_t k, int idx,
                                                     logic signed [31:0] v,
                                                     logic signed [31:0] f0,
                                                     logic signed [31:0] f1,
                                                     logic signed [31:0] t);
    mlpsgd_pkg::in_item_t it;
    it = '0;
    it.kind = k;
    it.param_index = idx[7:0];
    it.param_value = v;
    it.feature_current = f0;
    it.feature_energy = f1;
    it = '{k, idx[7:0], v, f0, f1, t, t, t, t, t, t};
    return it;
  endfunction

  function automatic mlpsgd_pkg::in_item_t random_item();
    mlpsgd_pkg::in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it = '0;
    it.param_index = 8'($urandom_range(255));
    it.param_value = $urandom;
    it.feature_current = pick_q(26);
    it.feature_energy = pick_q(26);
    it.target_0 = pick_q(26);
    it.target_1 = pick_q(26);
    it.target_2 = pick_q(26);
    it.target_3 = pick_q(26);
    it.target_4 = pick_q(26);
    it.target_5 = pick_q(26);
    if (sel < 25) it.kind = mlpsgd_pkg::KIND_INFER;
    else if (sel < 50) it.kind = mlpsgd_pkg::KIND_TRAIN;
    else if (sel < 80) begin
      it.kind = mlpsgd_pkg::KIND_LOAD;
      it.param_value = pick_q(23);
    end else it.kind = mlpsgd_pkg::KIND_READ;
    return it;
  endfunction

  task automatic push(mlpsgd_pkg::in_item_t it);
    item_q = {item_q, it};
    n_queued++;
  endtask

  task automatic reload_store();
    for (int a = 0; a < STORE_N; a++)
      push(make_item(mlpsgd_pkg::KIND_LOAD, a, pick_q(23), '0, '0, '0));
  endtask

  task automatic drain();
    do @(negedge clk); while (n_taken != n_queued || result_q.size() != 0);
  endtask

  task automatic set_rate(logic [24:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    lr_shadow = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int idle, int stall, int n, bit refresh);
    @(posedge clk);
    idle_pct = idle;
    stall_pct = stall;
    if (refresh) reload_store();
    repeat (n) push(random_item());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every entry written before anything reads it
    @(posedge clk);
    reload_store();
    push(make_item(mlpsgd_pkg::KIND_LOAD, 10, Q_MAX, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_READ, 10, '0, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_LOAD, 10, Q_MIN, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_READ, 10, '1, '1, '1, '1));
    push(make_item(mlpsgd_pkg::KIND_LOAD, 10, 32'sh0080_0000, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_READ, 0, '0, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_READ, STORE_N - 1, '0, '0, '0, '0));
    // indexes past the store
    push(make_item(mlpsgd_pkg::KIND_LOAD, STORE_N, Q_MAX, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_LOAD, 255, Q_MAX, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_READ, STORE_N, '0, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_READ, 255, '0, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_INFER, 0, '0, '0, '0, '0));
    push(make_item(mlpsgd_pkg::KIND_INFER, 255, '1, Q_MAX, Q_MIN, Q_MAX));
    push(make_item(mlpsgd_pkg::KIND_INFER, 0, '0, Q_MIN, Q_MAX, '0));
    push(make_item(mlpsgd_pkg::KIND_TRAIN, 0, '0, 32'sh0100_0000, 32'sh0080_0000, Q_MAX));
    push(make_item(mlpsgd_pkg::KIND_TRAIN, 0, '0, 32'sh0100_0000, -32'sh0080_0000, Q_MIN));
    push(make_item(mlpsgd_pkg::KIND_TRAIN, 0, '0, '0, '0, '0));
    drain();

    set_rate(25'd0);
    push(make_item(mlpsgd_pkg::KIND_TRAIN, 0, '0, 32'sh0200_0000, 32'sh0100_0000,
                   32'sh0300_0000));
    drain();
    set_rate('1);
    push(make_item(mlpsgd_pkg::KIND_TRAIN, 0, '0, 32'sh0010_0000, 32'sh0010_0000,
                   32'sh0010_0000));
    drain();

    set_rate(mlpsgd_pkg::LR_RESET);
    random_phase(0, 0, 100, 1'b0);
    set_rate(25'd1 << 24);
    random_phase(61, 0, 100, 1'b0);
    set_rate(25'($urandom_range(0, 25'h1ff_ffff)));
    random_phase(0, 61, 100, 1'b1);
    set_rate(25'd0);
    random_phase(7, 7, 80, 1'b0);
    set_rate('1);
    random_phase(7, 7, 60, 1'b0);
    set_rate(mlpsgd_pkg::LR_RESET);
    random_phase(0, 0, 80, 1'b0);

    repeat (40) @(posedge clk);
    $display("covered %0d infer, %0d train, %0d load, %0d read beats; %0d results checked",
             kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], n_results);
    $display("learning rates zero, reset, one, full scale and random under four idle mixes");
    if (n_errors == 0 && result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("timeout with %0d results outstanding", result_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
